/* rtl/fnu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face normal unit package
// Shared widths, request and response types, and sideband structs.
// ----------------------------------------------------------------------------
package fnu_pkg;

  localparam int CoordW          = 16;
  localparam int EdgeW           = CoordW + 1;
  localparam int ProdW           = 2 * EdgeW;
  localparam int CrossW          = ProdW + 1;
  localparam int MagW            = ProdW;
  localparam int HalfW           = MagW / 2;
  localparam int SumW            = 2 * MagW;
  localparam int RootW           = MagW;
  localparam int NormW           = 16;
  localparam int NormFracBitsDef = 14;

  typedef struct packed {
    logic signed [CoordW-1:0] p0_x;
    logic signed [CoordW-1:0] p0_y;
    logic signed [CoordW-1:0] p0_z;
    logic signed [CoordW-1:0] p1_x;
    logic signed [CoordW-1:0] p1_y;
    logic signed [CoordW-1:0] p1_z;
    logic signed [CoordW-1:0] p2_x;
    logic signed [CoordW-1:0] p2_y;
    logic signed [CoordW-1:0] p2_z;
  } fnu_req_t;

  typedef struct packed {
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    degenerate;
  } fnu_rsp_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } fnu_flags_t;

  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    fnu_flags_t           flags;
  } fnu_side_t;

endpackage

/* rtl/face_normal_unit_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face normal unit core
// Unit normal of a triangle: edge cross product scaled by its length.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the square root takes one root bit per
// stage and the dividers one quotient bit per stage, all fully pipelined.
// The whole pipeline advances together and holds while the output stalls.
// Reset clears only the valid bits; the data registers are not reset.
module face_normal_unit_core #(
  parameter int NORMAL_FRAC_BITS = fnu_pkg::NormFracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  fnu_pkg::fnu_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_stall_i,
  output fnu_pkg::fnu_rsp_t rsp_o
);

  localparam int EdgeW  = fnu_pkg::EdgeW;
  localparam int ProdW  = fnu_pkg::ProdW;
  localparam int CrossW = fnu_pkg::CrossW;
  localparam int MagW   = fnu_pkg::MagW;
  localparam int HalfW  = fnu_pkg::HalfW;
  localparam int SumW   = fnu_pkg::SumW;
  localparam int RootW  = fnu_pkg::RootW;

  // Every stage moves when the output register is empty or being taken.
  logic en;
  assign en          = !(rsp_valid_o && rsp_stall_i);
  assign req_stall_o = !en;

  // Stage 1: edge vectors a = p0 - p1 and b = p1 - p2.
  logic signed [EdgeW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic                    v1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= {req_i.p0_x[15], req_i.p0_x} - {req_i.p1_x[15], req_i.p1_x};
      ay_q <= {req_i.p0_y[15], req_i.p0_y} - {req_i.p1_y[15], req_i.p1_y};
      az_q <= {req_i.p0_z[15], req_i.p0_z} - {req_i.p1_z[15], req_i.p1_z};
      bx_q <= {req_i.p1_x[15], req_i.p1_x} - {req_i.p2_x[15], req_i.p2_x};
      by_q <= {req_i.p1_y[15], req_i.p1_y} - {req_i.p2_y[15], req_i.p2_y};
      bz_q <= {req_i.p1_z[15], req_i.p1_z} - {req_i.p2_z[15], req_i.p2_z};
    end
  end

  // Stage 2: the six signed products of the cross product.
  logic signed [ProdW-1:0] pxa_q, pxb_q, pya_q, pyb_q, pza_q, pzb_q;
  logic                    v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxa_q <= ay_q * bz_q;
      pxb_q <= az_q * by_q;
      pya_q <= az_q * bx_q;
      pyb_q <= ax_q * bz_q;
      pza_q <= ax_q * by_q;
      pzb_q <= ay_q * bx_q;
    end
  end

  // Stage 3: cross product components, split into magnitude and sign.
  logic signed [CrossW-1:0] cx, cy, cz;
  fnu_pkg::fnu_side_t       side3_d, side3_q;
  logic                     v3_q;

  always_comb begin
    cx = {pxa_q[ProdW-1], pxa_q} - {pxb_q[ProdW-1], pxb_q};
    cy = {pya_q[ProdW-1], pya_q} - {pyb_q[ProdW-1], pyb_q};
    cz = {pza_q[ProdW-1], pza_q} - {pzb_q[ProdW-1], pzb_q};
    side3_d.mag[0]      = cx[CrossW-1] ? MagW'(-cx) : cx[MagW-1:0];
    side3_d.mag[1]      = cy[CrossW-1] ? MagW'(-cy) : cy[MagW-1:0];
    side3_d.mag[2]      = cz[CrossW-1] ? MagW'(-cz) : cz[MagW-1:0];
    side3_d.flags.neg   = {cz[CrossW-1], cy[CrossW-1], cx[CrossW-1]};
    side3_d.flags.degen = (cx == '0) && (cy == '0) && (cz == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q <= side3_d;
    end
  end

  // Stage 4: each square is built from half-width partial products.
  logic [2:0][ProdW-1:0] hh_q, hl_q, ll_q;
  fnu_pkg::fnu_side_t    side4_q;
  logic                  v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        hh_q[j] <= side3_q.mag[j][MagW-1:HalfW] * side3_q.mag[j][MagW-1:HalfW];
        hl_q[j] <= side3_q.mag[j][MagW-1:HalfW] * side3_q.mag[j][HalfW-1:0];
        ll_q[j] <= side3_q.mag[j][HalfW-1:0] * side3_q.mag[j][HalfW-1:0];
      end
      side4_q <= side3_q;
    end
  end

  // Stage 5: the three squares.
  logic [2:0][SumW-1:0] sq_d, sq_q;
  fnu_pkg::fnu_side_t   side5_q;
  logic                 v5_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_d[j] = (SumW'(hh_q[j]) << (2 * HalfW)) + (SumW'(hl_q[j]) << (HalfW + 1))
              + SumW'(ll_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q    <= sq_d;
      side5_q <= side4_q;
    end
  end

  // Stage 6: sum of squares.
  logic [SumW-1:0]    sum_q;
  fnu_pkg::fnu_side_t side6_q;
  logic               v6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q   <= sq_q[0] + sq_q[1] + sq_q[2];
      side6_q <= side5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= req_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Length: floor of the square root of the sum of squares.
  logic               sq_valid;
  logic [RootW-1:0]   root;
  fnu_pkg::fnu_side_t sq_side;

  fnu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .sum_i   (sum_q),
    .side_i  (side6_q),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  // A zero cross product divides by one, which gives a zero normal.
  logic [RootW-1:0] len;
  assign len = sq_side.flags.degen ? RootW'(1) : root;

  logic              div_valid;
  fnu_pkg::fnu_rsp_t div_rsp;

  fnu_div #(
    .NormFracBits (NORMAL_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .len_i   (len),
    .mag_i   (sq_side.mag),
    .flags_i (sq_side.flags),
    .valid_o (div_valid),
    .rsp_o   (div_rsp)
  );

  // Output register.
  logic              rsp_valid_q;
  fnu_pkg::fnu_rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      rsp_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= div_rsp;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.degenerate |->
      rsp_o.normal_x == '0 && rsp_o.normal_y == '0 && rsp_o.normal_z == '0)
    else $error("degenerate response with a nonzero normal");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_stall_o |-> rsp_valid_o && rsp_stall_i)
    else $error("input stalled without a blocked response");

  a_hold_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("blocked response lost or changed");
`endif

endmodule

/* rtl/fnu_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face normal unit square root pipeline
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module fnu_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [fnu_pkg::SumW-1:0]  sum_i,
  input  fnu_pkg::fnu_side_t        side_i,
  output logic                      valid_o,
  output logic [fnu_pkg::RootW-1:0] root_o,
  output fnu_pkg::fnu_side_t        side_o
);

  localparam int RootW = fnu_pkg::RootW;
  localparam int SumW  = fnu_pkg::SumW;
  localparam int RemW  = RootW + 2;

  logic [RemW-1:0]    rem_w  [RootW+1];
  logic [RootW-1:0]   root_w [RootW+1];
  logic [SumW-1:0]    s_w    [RootW+1];
  fnu_pkg::fnu_side_t side_w [RootW+1];
  logic [RootW:0]     v_w;

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign s_w[0]    = sum_i;
  assign side_w[0] = side_i;
  assign v_w[0]    = valid_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW+1:0]    rem_cat;
    logic [RemW+1:0]    trial;
    logic               ge;
    logic [RemW-1:0]    rem_d, rem_q;
    logic [RootW-1:0]   root_d, root_q;
    logic [SumW-1:0]    s_q;
    fnu_pkg::fnu_side_t side_q;
    logic               v_q;

    always_comb begin
      rem_cat = {rem_w[k], s_w[k][SumW-1 -: 2]};
      trial   = (RemW + 2)'({root_w[k], 2'b01});
      ge      = (rem_cat >= trial);
      rem_d   = ge ? RemW'(rem_cat - trial) : RemW'(rem_cat);
      root_d  = {root_w[k][RootW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        s_q    <= {s_w[k][SumW-3:0], 2'b00};
        side_q <= side_w[k];
      end
    end

    assign rem_w[k+1]  = rem_q;
    assign root_w[k+1] = root_q;
    assign s_w[k+1]    = s_q;
    assign side_w[k+1] = side_q;
    assign v_w[k+1]    = v_q;
  end

  assign valid_o = v_w[RootW];
  assign root_o  = root_w[RootW];
  assign side_o  = side_w[RootW];

endmodule

/* rtl/fnu_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face normal unit divider pipeline
// Three restoring dividers sharing one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fnu_div #(
  parameter int NormFracBits = fnu_pkg::NormFracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [fnu_pkg::RootW-1:0]           len_i,
  input  logic [2:0][fnu_pkg::MagW-1:0]       mag_i,
  input  fnu_pkg::fnu_flags_t                 flags_i,
  output logic                                valid_o,
  output fnu_pkg::fnu_rsp_t                   rsp_o
);

  localparam int RootW = fnu_pkg::RootW;
  localparam int NormW = fnu_pkg::NormW;
  localparam int QW    = NormFracBits + 1;

  logic [2:0][RootW-1:0] rem_w   [QW+1];
  logic [2:0][QW-1:0]    q_w     [QW+1];
  logic [RootW-1:0]      len_w   [QW+1];
  fnu_pkg::fnu_flags_t   flags_w [QW+1];
  logic [QW:0]           v_w;

  // The quotient stays below 2^QW, so the top of the shifted dividend is
  // already smaller than the divisor.
  for (genvar j = 0; j < 3; j++) begin : g_init
    assign rem_w[0][j] = RootW'(mag_i[j] >> 1);
    assign q_w[0][j]   = '0;
  end
  assign len_w[0]   = len_i;
  assign flags_w[0] = flags_i;
  assign v_w[0]     = valid_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [2:0][RootW-1:0] rem_d, rem_q;
    logic [2:0][QW-1:0]    q_d, q_q;
    logic [RootW-1:0]      len_q;
    fnu_pkg::fnu_flags_t   flags_q;
    logic                  v_q;

    for (genvar j = 0; j < 3; j++) begin : g_comp
      logic            nbit;
      logic [RootW:0]  rem_sh;
      logic            ge;
      if (k == 0) begin : g_first
        assign nbit = mag_i[j][0];
      end else begin : g_rest
        assign nbit = 1'b0;
      end
      always_comb begin
        rem_sh   = {rem_w[k][j], nbit};
        ge       = (rem_sh >= {1'b0, len_w[k]});
        rem_d[j] = ge ? RootW'(rem_sh - {1'b0, len_w[k]}) : RootW'(rem_sh);
        q_d[j]   = {q_w[k][j][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q   <= rem_d;
        q_q     <= q_d;
        len_q   <= len_w[k];
        flags_q <= flags_w[k];
      end
    end

    assign rem_w[k+1]   = rem_q;
    assign q_w[k+1]     = q_q;
    assign len_w[k+1]   = len_q;
    assign flags_w[k+1] = flags_q;
    assign v_w[k+1]     = v_q;
  end

  logic [2:0][NormW-1:0] norm;
  for (genvar j = 0; j < 3; j++) begin : g_out
    logic [QW+NormW-1:0] q_ext;
    logic [NormW-1:0]    q_lo;
    always_comb begin
      q_ext   = {{NormW{1'b0}}, q_w[QW][j]};
      q_lo    = q_ext[NormW-1:0];
      norm[j] = flags_w[QW].neg[j] ? NormW'(~q_lo + 1'b1) : q_lo;
    end
  end

  assign valid_o          = v_w[QW];
  assign rsp_o.normal_x   = norm[0];
  assign rsp_o.normal_y   = norm[1];
  assign rsp_o.normal_z   = norm[2];
  assign rsp_o.degenerate = flags_w[QW].degen;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Face normal unit testbench
// Drives triangles into the core with random bursts and gaps, stalls the
// output on a pattern of its own, and checks every response field against a
// unit-normal predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LatencyCycles = 60;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              req_valid_i = 1'b0;
  logic              req_stall_o;
  fnu_pkg::fnu_req_t req_i = '0;
  logic              rsp_valid_o;
  logic              rsp_stall_i = 1'b0;
  fnu_pkg::fnu_rsp_t rsp_o;

  // Triangles waiting to be driven, and normals waiting to come back.
  fnu_pkg::fnu_req_t pending_tris[$];
  fnu_pkg::fnu_rsp_t expected_normals[$];
  int       mismatch_count = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_phase = 0;
  // The sender holds off while this is set, until every normal has returned.
  bit       drain_hold = 1'b0;

  face_normal_unit_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // Integer square root, rounded down, of a sum of squares below 2^70.
  function automatic logic [35:0] isqrt_sum(logic [71:0] sum);
    logic [35:0] root;
    logic [35:0] trial;
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      trial = root | (36'd1 << b);
      if ({36'd0, trial} * {36'd0, trial} <= sum) root = trial;
    end
    return root;
  endfunction

  // Scale one cross-product component by the length, truncated toward zero.
  function automatic logic signed [15:0] scale_component(
      logic signed [35:0] comp, logic [35:0] len);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = comp < 0 ? 64'(-comp) : 64'(comp);
    quo = (mag << fnu_pkg::NormFracBitsDef) / len;
    return comp < 0 ? 16'(-quo) : 16'(quo);
  endfunction

  function automatic fnu_pkg::fnu_rsp_t predict_normal(fnu_pkg::fnu_req_t t);
    logic signed [35:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [71:0]        sum;
    logic [35:0]        len;
    fnu_pkg::fnu_rsp_t  r;
    ax = 36'(t.p0_x) - 36'(t.p1_x);
    ay = 36'(t.p0_y) - 36'(t.p1_y);
    az = 36'(t.p0_z) - 36'(t.p1_z);
    bx = 36'(t.p1_x) - 36'(t.p2_x);
    by = 36'(t.p1_y) - 36'(t.p2_y);
    bz = 36'(t.p1_z) - 36'(t.p2_z);
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    sum = 72'(cx) * 72'(cx) + 72'(cy) * 72'(cy) + 72'(cz) * 72'(cz);
    r.degenerate = (cx == 0 && cy == 0 && cz == 0);
    len = r.degenerate ? 36'd1 : isqrt_sum(sum);
    if (len == 36'd0) len = 36'd1;
    r.normal_x = scale_component(cx, len);
    r.normal_y = scale_component(cy, len);
    r.normal_z = scale_component(cz, len);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 255)) - 16'sd128;
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  function automatic fnu_pkg::fnu_req_t make_tri(int mode);
    fnu_pkg::fnu_req_t t;
    t.p0_x = rand_coord(mode); t.p0_y = rand_coord(mode); t.p0_z = rand_coord(mode);
    t.p1_x = rand_coord(mode); t.p1_y = rand_coord(mode); t.p1_z = rand_coord(mode);
    t.p2_x = rand_coord(mode); t.p2_y = rand_coord(mode); t.p2_z = rand_coord(mode);
    return t;
  endfunction

  // Driver: bursts of random length separated by random gaps. A request that
  // has been raised stays put until the core stops stalling it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && !req_stall_o) begin
        expected_normals.push_back(predict_normal(req_i));
        void'(pending_tris.pop_front());
      end
      if (req_valid_i && req_stall_o) begin
        // Hold the stalled request unchanged.
      end else if (drain_hold || pending_tris.size() == 0) begin
        req_valid_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        req_valid_i <= 1'b0;
      end else begin
        req_valid_i <= 1'b1;
        req_i <= pending_tris[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  // Monitor and output stall pattern: long free-running stretches mixed with
  // choppy stretches, so stalls hit every stage of the pipeline.
  always @(posedge clk_i) begin
    fnu_pkg::fnu_rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_o && !rsp_stall_i) begin
        if (expected_normals.size() == 0) begin
          report_mismatch("unexpected response", 0, 0);
        end else begin
          want = expected_normals.pop_front();
          if (rsp_o.normal_x !== want.normal_x)
            report_mismatch("normal_x", rsp_o.normal_x, want.normal_x);
          if (rsp_o.normal_y !== want.normal_y)
            report_mismatch("normal_y", rsp_o.normal_y, want.normal_y);
          if (rsp_o.normal_z !== want.normal_z)
            report_mismatch("normal_z", rsp_o.normal_z, want.normal_z);
          if (rsp_o.degenerate !== want.degenerate)
            report_mismatch("degenerate", rsp_o.degenerate, want.degenerate);
        end
      end
      stall_phase = (stall_phase + 1) % 400;
      if (stall_phase < 150) rsp_stall_i <= 1'b0;
      else if (stall_phase < 300) rsp_stall_i <= ($urandom_range(0, 2) == 0);
      else rsp_stall_i <= ($urandom_range(0, 5) != 0);
    end
  end

  initial begin
    fnu_pkg::fnu_req_t t;
    // Directed triangles: extremes, zero-length edges, collinear points, a
    // plain axis-aligned triangle in each plane, and signs of each axis.
    pending_tris.push_back('0);
    t = '0; t.p0_x = 16'sh7fff; t.p1_x = 16'sh8000; t.p2_x = 16'sh7fff;
    pending_tris.push_back(t);
    t = '0; t.p0_x = 16'sd256; t.p2_x = -16'sd256;
    pending_tris.push_back(t);
    t = '0; t.p0_x = 16'sd256; t.p2_y = 16'sd256;
    pending_tris.push_back(t);
    t = '0; t.p0_y = 16'sd256; t.p2_z = 16'sd256;
    pending_tris.push_back(t);
    t = '0; t.p0_z = 16'sd256; t.p2_x = 16'sd256;
    pending_tris.push_back(t);
    t = '0; t.p0_x = 16'sh8000; t.p2_y = 16'sh8000;
    pending_tris.push_back(t);
    t = '0; t.p0_x = 16'sh7fff; t.p0_y = 16'sh8000; t.p1_z = 16'sh7fff;
    t.p2_x = 16'sh8000; t.p2_y = 16'sh7fff; t.p2_z = 16'sh8000;
    pending_tris.push_back(t);
    t = '0; t.p0_x = 16'sh8000; t.p0_y = 16'sh8000; t.p0_z = 16'sh8000;
    t.p1_x = 16'sh7fff; t.p1_y = 16'sh7fff; t.p2_z = 16'sh7fff;
    pending_tris.push_back(t);
    t = '0; t.p0_x = 16'sd1; t.p2_y = 16'sd1;
    pending_tris.push_back(t);
    t = '0; t.p0_x = 16'sd1; t.p0_y = 16'sd1; t.p0_z = 16'sd1;
    t.p1_x = 16'sd2; t.p1_y = 16'sd2; t.p1_z = 16'sd2;
    pending_tris.push_back(t);
    for (int i = 0; i < 6; i++) pending_tris.push_back(make_tri(2));
    for (int i = 0; i < 4; i++) pending_tris.push_back('1 ^ make_tri(1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 700; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          // Collinear points give a degenerate triangle.
          t = make_tri(1);
          t.p2_x = t.p1_x - (t.p0_x - t.p1_x);
          t.p2_y = t.p1_y - (t.p0_y - t.p1_y);
          t.p2_z = t.p1_z - (t.p0_z - t.p1_z);
        end
        1, 2: t = make_tri(1);
        3:    t = make_tri(2);
        default: t = make_tri(0);
      endcase
      pending_tris.push_back(t);
      if (i == 350) begin
        // Let the sender pause until every normal already sent has returned.
        wait (pending_tris.size() <= 1);
        drain_hold = 1'b1;
        wait (pending_tris.size() <= 1 && !req_valid_i && expected_normals.size() == 0);
        drain_hold = 1'b0;
      end
    end
    wait (pending_tris.size() == 0 && expected_normals.size() == 0);
    repeat (LatencyCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d responses outstanding", expected_normals.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* face_normal_unit_core.f */
rtl/fnu_pkg.sv
rtl/fnu_sqrt.sv
rtl/fnu_div.sv
rtl/face_normal_unit_core.sv
tb/testbench.sv
